[hw/rtl/kar_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key auto-repeat package
// Shared widths, register indexes, reset values and the divide-by-three helper.
// ----------------------------------------------------------------------------
package kar_pkg;

    localparam int TIME_W  = 32;
    localparam int KEY_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    typedef logic [TIME_W-1:0] time_val_t;
    typedef logic [KEY_W-1:0]  key_mask_t;
    typedef logic [CFG_W-1:0]  cfg_data_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REPEAT_INTERVAL = 1'b0,
        REG_HOLD_THRESHOLD  = 1'b1
    } cfg_index_t;

    localparam cfg_data_t REPEAT_RESET = 16'd200;
    localparam cfg_data_t HOLD_RESET   = 16'd1000;

    // Exact floor(x / 3) for any 16-bit x, by reciprocal multiplication.
    localparam int DIV3_SHIFT = 17;
    localparam logic [CFG_W:0] DIV3_RECIP = 17'(((1 << DIV3_SHIFT) + 2) / 3);

    function automatic cfg_data_t div3(input cfg_data_t x);
        logic [2*CFG_W:0] prod;
        prod = {{(CFG_W+1){1'b0}}, x} * {{CFG_W{1'b0}}, DIV3_RECIP};
        return prod[DIV3_SHIFT +: CFG_W];
    endfunction

endpackage

[hw/rtl/kar_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key auto-repeat input channel
// Carries one tick: the time value and the raw key levels.
// ----------------------------------------------------------------------------
interface kar_in_if;
    import kar_pkg::*;

    logic      valid;
    logic      ready;
    time_val_t now_time;
    key_mask_t key_levels;

    modport source (output valid, output now_time, output key_levels, input ready);
    modport sink   (input valid, input now_time, input key_levels, output ready);
endinterface

[hw/rtl/kar_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key auto-repeat output channel
// Carries one event mask for each tick.
// ----------------------------------------------------------------------------
interface kar_out_if;
    import kar_pkg::*;

    logic      valid;
    logic      ready;
    key_mask_t key_events;

    modport source (output valid, output key_events, input ready);
    modport sink   (input valid, input key_events, output ready);
endinterface

[hw/rtl/key_auto_repeat_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key auto-repeat core
// Typematic press and repeat detection for a bank of keys.
// ----------------------------------------------------------------------------
// Each transaction on key_in brings a tick time and the raw key levels; each
// produces exactly one transaction on evt_out holding the event mask.
// A tick is captured in an input register, evaluated combinationally against
// the per-key state and placed in the output register when that register is
// free or being taken.
// One tick is accepted every cycle while evt_out is not stalled; the per-key
// press and repeat state is updated as each tick moves to the output register.
// When the receiver stalls, the output register holds its transaction and
// the input register fills; key_in.ready then drops until evt_out is taken.
// The configuration port writes repeat_interval (index 0) and hold_threshold (index 1);
// the user must make writes only while the block is idle; it does not enforce this.
// Reset clears all key state, empties both registers and loads the
// register defaults of 200 and 1000 ticks.
// Keys at or above KEY_COUNT are ignored and report no events.
// ----------------------------------------------------------------------------
module key_auto_repeat_core #(
    parameter int KEY_COUNT = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    kar_in_if.sink                     key_in,
    kar_out_if.source                  evt_out,
    input  logic                       cfg_we,
    input  logic [kar_pkg::CFG_IDX_W-1:0] cfg_index,
    input  kar_pkg::cfg_data_t         cfg_data
);
    import kar_pkg::*;

    cfg_data_t repeat_interval_reg;
    cfg_data_t hold_threshold_reg;
    cfg_data_t fast_interval_reg;

    logic      s1_valid_reg;
    time_val_t s1_time_reg;
    key_mask_t s1_levels_reg;

    logic      out_valid_reg;
    key_mask_t out_events_reg;
    key_mask_t out_events_next;

    logic [KEY_COUNT-1:0] prev_level_reg;
    logic [KEY_COUNT-1:0] held_reg;
    time_val_t            press_stamp_reg [KEY_COUNT];
    time_val_t            last_fire_reg   [KEY_COUNT];

    logic [KEY_COUNT-1:0] prev_level_next;
    logic [KEY_COUNT-1:0] held_next;
    time_val_t            press_stamp_next [KEY_COUNT];
    time_val_t            last_fire_next   [KEY_COUNT];

    logic advance;
    logic s1_free;

    assign advance = s1_valid_reg && (!out_valid_reg || evt_out.ready);
    assign s1_free = !s1_valid_reg || advance;

    assign key_in.ready       = s1_free;
    assign evt_out.valid      = out_valid_reg;
    assign evt_out.key_events = out_events_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_interval_reg <= REPEAT_RESET;
            hold_threshold_reg  <= HOLD_RESET;
            fast_interval_reg   <= div3(REPEAT_RESET);
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    REG_REPEAT_INTERVAL:
                    begin
                        repeat_interval_reg <= cfg_data;
                        fast_interval_reg   <= div3(cfg_data);
                    end
                    REG_HOLD_THRESHOLD:  hold_threshold_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= key_in.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (evt_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_in.valid && s1_free)
        begin
            s1_time_reg   <= key_in.now_time;
            s1_levels_reg <= key_in.key_levels;
        end
        if (advance)
        begin
            out_events_reg <= out_events_next;
        end
    end

    always_comb
    begin
        time_val_t press_age;
        time_val_t fire_age;
        cfg_data_t gap;
        logic      level;
        out_events_next = '0;
        prev_level_next = prev_level_reg;
        held_next       = held_reg;
        press_age       = '0;
        fire_age        = '0;
        gap             = '0;
        level           = 1'b0;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            press_stamp_next[k] = press_stamp_reg[k];
            last_fire_next[k]   = last_fire_reg[k];
            level              = s1_levels_reg[k];
            prev_level_next[k] = level;
            press_age = s1_time_reg - press_stamp_reg[k];
            fire_age  = s1_time_reg - last_fire_reg[k];
            gap = (hold_threshold_reg != '0 &&
                   press_age > {{(TIME_W-CFG_W){1'b0}}, hold_threshold_reg})
                  ? fast_interval_reg : repeat_interval_reg;
            if (level && !prev_level_reg[k])
            begin
                press_stamp_next[k] = s1_time_reg;
                last_fire_next[k]   = s1_time_reg;
                held_next[k]        = 1'b1;
                out_events_next[k]  = 1'b1;
            end
            else if (!level && prev_level_reg[k])
            begin
                press_stamp_next[k] = '0;
                last_fire_next[k]   = '0;
                held_next[k]        = 1'b0;
            end
            else if (repeat_interval_reg != '0 && held_reg[k] &&
                     fire_age > {{(TIME_W-CFG_W){1'b0}}, gap})
            begin
                last_fire_next[k]  = s1_time_reg;
                out_events_next[k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= '0;
            held_reg       <= '0;
            for (int k = 0; k < KEY_COUNT; k++)
            begin
                press_stamp_reg[k] <= '0;
                last_fire_reg[k]   <= '0;
            end
        end
        else if (advance)
        begin
            prev_level_reg <= prev_level_next;
            held_reg       <= held_next;
            for (int k = 0; k < KEY_COUNT; k++)
            begin
                press_stamp_reg[k] <= press_stamp_next[k];
                last_fire_reg[k]   <= last_fire_next[k];
            end
        end
    end

    a_unused_keys_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        evt_out.valid |-> ((evt_out.key_events >> KEY_COUNT) == '0))
        else $error("Event reported for a key beyond KEY_COUNT.");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !evt_out.ready) |-> !key_in.ready)
        else $error("Input accepted while both registers are full.");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("Evaluated tick did not reach the output register.");

    a_release_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> ((out_events_next & ~s1_levels_reg) == '0))
        else $error("Event raised for a key that is not pressed.");

endmodule
